// ----- src/fdf_pkg.sv -----
// ----------------------------------------------------------------------------
// fdf_pkg
// shared types and constants for the frame stream deframer
// ----------------------------------------------------------------------------
package fdf_pkg;

  // intake queue depth between the byte front end and the parser
  localparam int QUEUE_DEPTH = 4;

  // configuration port
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CONTROL_LEN_LIMIT = 1'b0,
    REG_FIELD_LEN_LIMIT   = 1'b1
  } reg_index_t;

  localparam logic [CFG_DATA_W-1:0] CONTROL_LEN_LIMIT_RESET = 16'd512;
  localparam logic [CFG_DATA_W-1:0] FIELD_LEN_LIMIT_RESET   = 16'd256;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] control_len_limit;
    logic [CFG_DATA_W-1:0] field_len_limit;
  } cfg_t;

  // parser modes
  typedef enum logic [2:0] {
    MODE_CTRL_HDR  = 3'd0,
    MODE_FIELD_HDR = 3'd1,
    MODE_FIELD_PAY = 3'd2,
    MODE_FRAME_HDR = 3'd3,
    MODE_FRAME_PAY = 3'd4,
    MODE_DONE      = 3'd5,
    MODE_ERROR     = 3'd6
  } mode_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_CONTROL     = 3'd0,
    EV_FIELD_HDR   = 3'd1,
    EV_FIELD_BYTE  = 3'd2,
    EV_FRAME_HDR   = 3'd3,
    EV_FRAME_BYTE  = 3'd4,
    EV_STOPPED     = 3'd5,
    EV_FINISHED    = 3'd6,
    EV_ERROR       = 3'd7
  } event_t;

  // control frame types
  localparam logic [31:0] CTRL_ACCEPT = 32'd1;
  localparam logic [31:0] CTRL_START  = 32'd2;
  localparam logic [31:0] CTRL_STOP   = 32'd3;
  localparam logic [31:0] CTRL_READY  = 32'd4;
  localparam logic [31:0] CTRL_FINISH = 32'd5;

  // field type for content type
  localparam logic [31:0] FIELD_CONTENT_TYPE = 32'd1;

  // header byte counts at which each header word completes
  localparam logic [3:0] HDR_WORD1_END = 4'd4;
  localparam logic [3:0] HDR_WORD2_END = 4'd8;
  localparam logic [3:0] HDR_WORD3_END = 4'd12;

  // control length taken by the type word, and field header overhead
  localparam logic [15:0] CTRL_TYPE_BYTES = 16'd4;
  localparam logic [32:0] FIELD_HDR_BYTES = 33'd8;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [2:0]  control_kind;
    logic [31:0] item_length;
  } result_t;

endpackage

// ----- src/fdf_if.sv -----
// ----------------------------------------------------------------------------
// fdf_if
// valid/ready channels for stream bytes and parser events
// ----------------------------------------------------------------------------
interface fdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface fdf_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic [2:0]  control_kind;
  logic [31:0] item_length;

  modport source (output valid, output event_res, output payload_byte, output last_byte,
                  output control_kind, output item_length, input ready);
  modport sink   (input valid, input event_res, input payload_byte, input last_byte,
                  input control_kind, input item_length, output ready);
endinterface

// ----- src/fdf_byte_queue.sv -----
// ----------------------------------------------------------------------------
// fdf_byte_queue
// short byte queue between the intake and the parser
// ----------------------------------------------------------------------------
module fdf_byte_queue #(
  parameter int DEPTH = fdf_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  logic [7:0] push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output logic [7:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/fdf_parser.sv -----
// ----------------------------------------------------------------------------
// fdf_parser
// header assembly, frame checks and payload pass-through, one byte a cycle while the event output is not stalled
// ----------------------------------------------------------------------------
module fdf_parser (
  input  logic             clk,
  input  logic             rst,
  input  fdf_pkg::cfg_t    cfg,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  logic [7:0]       byte_data,
  output logic             res_valid,
  input  logic             res_ready,
  output fdf_pkg::result_t res
);

  fdf_pkg::mode_t mode;
  fdf_pkg::mode_t mode_next;
  logic [3:0]     header_count;
  logic [3:0]     header_count_next;
  logic [31:0]    header_word;
  logic [31:0]    header_word_next;
  logic [15:0]    saved_length;
  logic [15:0]    saved_length_next;
  logic [15:0]    control_left;
  logic [15:0]    control_left_next;
  logic [31:0]    payload_left;
  logic [31:0]    payload_left_next;

  logic             advance;
  logic             step_valid;
  fdf_pkg::result_t step_res;

  logic [31:0] w;
  logic [3:0]  count_inc;
  logic [31:0] payload_dec;
  logic        payload_last;
  logic        kind_open;
  logic        kind_stop;
  logic        kind_finish;
  logic        escape_bad;
  logic        ctrl_len_bad;
  logic        field_type_bad;
  logic        field_len_bad;
  logic [32:0] field_need;
  logic        field_fit_bad;
  logic [15:0] field_left;

  // the parser moves when a byte waits and the result slot is free or draining
  assign advance    = byte_valid && (!res_valid || res_ready);
  assign byte_ready = !res_valid || res_ready;

  assign w            = {header_word[23:0], byte_data};
  assign count_inc    = header_count + 1'b1;
  assign payload_dec  = payload_left - 1'b1;
  assign payload_last = (payload_dec == '0);

  assign kind_open   = (w == fdf_pkg::CTRL_ACCEPT) || (w == fdf_pkg::CTRL_START) ||
                       (w == fdf_pkg::CTRL_READY);
  assign kind_stop   = (w == fdf_pkg::CTRL_STOP);
  assign kind_finish = (w == fdf_pkg::CTRL_FINISH);

  assign escape_bad     = (w != '0);
  assign ctrl_len_bad   = (w > {16'd0, cfg.control_len_limit});
  assign field_type_bad = (w != fdf_pkg::FIELD_CONTENT_TYPE);
  assign field_len_bad  = (w > {16'd0, cfg.field_len_limit});
  assign field_need     = {1'b0, w} + fdf_pkg::FIELD_HDR_BYTES;
  assign field_fit_bad  = ({17'd0, control_left} < field_need);
  assign field_left     = control_left - field_need[15:0];

  // next state
  always_comb begin
    mode_next         = mode;
    header_count_next = header_count;
    header_word_next  = header_word;
    saved_length_next = saved_length;
    control_left_next = control_left;
    payload_left_next = payload_left;
    unique case (mode)
      fdf_pkg::MODE_FIELD_PAY, fdf_pkg::MODE_FRAME_PAY: begin
        payload_left_next = payload_dec;
        if (payload_last) begin
          if (mode == fdf_pkg::MODE_FIELD_PAY && control_left != '0) begin
            mode_next = fdf_pkg::MODE_FIELD_HDR;
          end else begin
            mode_next = fdf_pkg::MODE_FRAME_HDR;
          end
        end
      end
      fdf_pkg::MODE_CTRL_HDR: begin
        header_word_next  = w;
        header_count_next = count_inc;
        priority if (count_inc == fdf_pkg::HDR_WORD1_END) begin
          if (escape_bad) begin
            mode_next         = fdf_pkg::MODE_ERROR;
            header_count_next = '0;
          end
        end else if (count_inc == fdf_pkg::HDR_WORD2_END) begin
          if (ctrl_len_bad) begin
            mode_next         = fdf_pkg::MODE_ERROR;
            header_count_next = '0;
          end else begin
            saved_length_next = w[15:0];
          end
        end else if (count_inc >= fdf_pkg::HDR_WORD3_END) begin
          header_count_next = '0;
          priority if (kind_open) begin
            if (saved_length > fdf_pkg::CTRL_TYPE_BYTES) begin
              mode_next         = fdf_pkg::MODE_FIELD_HDR;
              control_left_next = saved_length - fdf_pkg::CTRL_TYPE_BYTES;
            end else begin
              mode_next = fdf_pkg::MODE_FRAME_HDR;
            end
          end else if (kind_stop || kind_finish) begin
            mode_next = fdf_pkg::MODE_DONE;
          end else begin
            mode_next = fdf_pkg::MODE_ERROR;
          end
        end else begin
          mode_next = mode;
        end
      end
      fdf_pkg::MODE_FIELD_HDR: begin
        header_word_next  = w;
        header_count_next = count_inc;
        priority if (count_inc == fdf_pkg::HDR_WORD1_END) begin
          if (field_type_bad) begin
            mode_next         = fdf_pkg::MODE_ERROR;
            header_count_next = '0;
          end
        end else if (count_inc >= fdf_pkg::HDR_WORD2_END) begin
          header_count_next = '0;
          if (field_len_bad || field_fit_bad) begin
            mode_next = fdf_pkg::MODE_ERROR;
          end else begin
            control_left_next = field_left;
            payload_left_next = w;
            if (w != '0) begin
              mode_next = fdf_pkg::MODE_FIELD_PAY;
            end else if (field_left != '0) begin
              mode_next = fdf_pkg::MODE_FIELD_HDR;
            end else begin
              mode_next = fdf_pkg::MODE_FRAME_HDR;
            end
          end
        end else begin
          mode_next = mode;
        end
      end
      fdf_pkg::MODE_FRAME_HDR: begin
        header_word_next  = w;
        header_count_next = count_inc;
        if (count_inc >= fdf_pkg::HDR_WORD1_END) begin
          if (w == '0) begin
            // zero length word is the control escape
            mode_next         = fdf_pkg::MODE_CTRL_HDR;
            header_count_next = fdf_pkg::HDR_WORD1_END;
          end else begin
            header_count_next = '0;
            payload_left_next = w;
            mode_next         = fdf_pkg::MODE_FRAME_PAY;
          end
        end
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // result of the current byte
  always_comb begin
    step_valid            = 1'b0;
    step_res.event_res    = fdf_pkg::EV_ERROR;
    step_res.payload_byte = '0;
    step_res.last_byte    = 1'b0;
    step_res.control_kind = '0;
    step_res.item_length  = '0;
    unique case (mode)
      fdf_pkg::MODE_FIELD_PAY, fdf_pkg::MODE_FRAME_PAY: begin
        step_valid            = 1'b1;
        step_res.event_res    = (mode == fdf_pkg::MODE_FIELD_PAY) ?
                                fdf_pkg::EV_FIELD_BYTE : fdf_pkg::EV_FRAME_BYTE;
        step_res.payload_byte = byte_data;
        step_res.last_byte    = payload_last;
      end
      fdf_pkg::MODE_CTRL_HDR: begin
        priority if (count_inc == fdf_pkg::HDR_WORD1_END) begin
          step_valid = escape_bad;
        end else if (count_inc == fdf_pkg::HDR_WORD2_END) begin
          step_valid = ctrl_len_bad;
        end else if (count_inc >= fdf_pkg::HDR_WORD3_END) begin
          step_valid = 1'b1;
          priority if (kind_open) begin
            step_res.event_res    = fdf_pkg::EV_CONTROL;
            step_res.control_kind = w[2:0];
            step_res.item_length  = {16'd0, saved_length};
          end else if (kind_stop) begin
            step_res.event_res = fdf_pkg::EV_STOPPED;
          end else if (kind_finish) begin
            step_res.event_res = fdf_pkg::EV_FINISHED;
          end else begin
            step_res.event_res = fdf_pkg::EV_ERROR;
          end
        end else begin
          step_valid = 1'b0;
        end
      end
      fdf_pkg::MODE_FIELD_HDR: begin
        priority if (count_inc == fdf_pkg::HDR_WORD1_END) begin
          step_valid = field_type_bad;
        end else if (count_inc >= fdf_pkg::HDR_WORD2_END) begin
          step_valid = 1'b1;
          if (!(field_len_bad || field_fit_bad)) begin
            step_res.event_res   = fdf_pkg::EV_FIELD_HDR;
            step_res.item_length = w;
          end
        end else begin
          step_valid = 1'b0;
        end
      end
      fdf_pkg::MODE_FRAME_HDR: begin
        if (count_inc >= fdf_pkg::HDR_WORD1_END && w != '0) begin
          step_valid           = 1'b1;
          step_res.event_res   = fdf_pkg::EV_FRAME_HDR;
          step_res.item_length = w;
        end
      end
      default: begin
        // done and error modes answer every byte with an error
        step_valid = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= fdf_pkg::MODE_CTRL_HDR;
      header_count <= '0;
      header_word  <= '0;
      saved_length <= '0;
      control_left <= '0;
      payload_left <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (advance) begin
        mode         <= mode_next;
        header_count <= header_count_next;
        header_word  <= header_word_next;
        saved_length <= saved_length_next;
        control_left <= control_left_next;
        payload_left <= payload_left_next;
        res_valid    <= step_valid;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_valid) begin
      res <= step_res;
    end
  end

endmodule

// ----- src/frame_stream_deframer_core.sv -----
// ----------------------------------------------------------------------------
// frame_stream_deframer_core
// byte-serial reader for length-prefixed frames with escaped control frames
// ----------------------------------------------------------------------------
//
//   channel        dir   handshake      beat contents
//   byte_stream    sink  valid/ready    data_byte
//   event_stream   src   valid/ready    event_res, payload_byte, last_byte,
//                                       control_kind, item_length
//   config write   sink  write_en       reg_index, write_data
//
// one beat a cycle in, at most one event a cycle out; a byte goes from acceptance
// to its event through a queue slot, then the parser output register
// the parser loop over header and length state sets the one-byte-per-cycle pace
// rst is synchronous: queue emptied, parser back to control header mode,
// limits back to 512 and 256
// a stalled event stream holds the parser; the byte queue keeps taking beats
// until it fills, then drops byte_stream.ready
//
module frame_stream_deframer_core #(
  parameter int QUEUE_DEPTH = fdf_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  fdf_byte_if.sink                       byte_stream,
  fdf_event_if.source                    event_stream,
  input  logic                           write_en,
  input  logic [fdf_pkg::CFG_INDEX_W-1:0] reg_index,
  input  logic [fdf_pkg::CFG_DATA_W-1:0]  write_data
);

  fdf_pkg::cfg_t    cfg;
  fdf_pkg::result_t res;

  logic       q_valid;
  logic       q_ready;
  logic [7:0] q_data;

  // limit registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.control_len_limit <= fdf_pkg::CONTROL_LEN_LIMIT_RESET;
      cfg.field_len_limit   <= fdf_pkg::FIELD_LEN_LIMIT_RESET;
    end else if (write_en) begin
      unique case (fdf_pkg::reg_index_t'(reg_index))
        fdf_pkg::REG_CONTROL_LEN_LIMIT: cfg.control_len_limit <= write_data;
        fdf_pkg::REG_FIELD_LEN_LIMIT:   cfg.field_len_limit   <= write_data;
        default:                        cfg <= cfg;
      endcase
    end
  end

  // front: byte intake queue
  fdf_byte_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (byte_stream.valid),
    .push_ready (byte_stream.ready),
    .push_data  (byte_stream.data_byte),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // back: header assembly, checks and payload pass-through
  fdf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (q_valid),
    .byte_ready (q_ready),
    .byte_data  (q_data),
    .res_valid  (event_stream.valid),
    .res_ready  (event_stream.ready),
    .res        (res)
  );

  // result fields onto the event channel
  assign event_stream.event_res    = res.event_res;
  assign event_stream.payload_byte = res.payload_byte;
  assign event_stream.last_byte    = res.last_byte;
  assign event_stream.control_kind = res.control_kind;
  assign event_stream.item_length  = res.item_length;

endmodule

// ----- src/fdf_checker.sv -----
// ----------------------------------------------------------------------------
// fdf_checker
// port-level checks on the event stream of the deframer
// ----------------------------------------------------------------------------
module fdf_checker (
  input logic        clk,
  input logic        rst,
  input logic        ev_valid,
  input logic        ev_ready,
  input logic [2:0]  event_res,
  input logic [7:0]  payload_byte,
  input logic        last_byte,
  input logic [2:0]  control_kind,
  input logic [31:0] item_length
);

  logic ended;
  logic ev_accept;
  logic ev_terminal;

  assign ev_accept   = ev_valid && ev_ready;
  assign ev_terminal = (event_res == fdf_pkg::EV_ERROR) ||
                       (event_res == fdf_pkg::EV_STOPPED) ||
                       (event_res == fdf_pkg::EV_FINISHED);

  // set once an error, stop or finish event has gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      ended <= 1'b0;
    end else if (ev_accept && ev_terminal) begin
      ended <= 1'b1;
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_ready |=> ev_valid)
    else $error("event valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_ready |=> $stable(event_res) && $stable(payload_byte) &&
      $stable(last_byte) && $stable(control_kind) && $stable(item_length))
    else $error("event payload changed while stalled");

  a_sticky_end: assert property (@(posedge clk) disable iff (rst)
    ended && ev_valid |-> event_res == fdf_pkg::EV_ERROR)
    else $error("non-error event after stream end or error");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !ev_valid)
    else $error("event valid right after reset");

endmodule

bind frame_stream_deframer_core fdf_checker u_fdf_checker (
  .clk          (clk),
  .rst          (rst),
  .ev_valid     (event_stream.valid),
  .ev_ready     (event_stream.ready),
  .event_res    (event_stream.event_res),
  .payload_byte (event_stream.payload_byte),
  .last_byte    (event_stream.last_byte),
  .control_kind (event_stream.control_kind),
  .item_length  (event_stream.item_length)
);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the frame stream deframer: feeds a framed byte
// stream of control frames, content-type fields and data frames, predicts
// every event in a cycle-free model of the parser and compares each event
// beat field by field, across several limit settings and idling patterns
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            write_en;
  logic [fdf_pkg::CFG_INDEX_W-1:0] reg_index;
  logic [fdf_pkg::CFG_DATA_W-1:0]  write_data;

  fdf_byte_if  in_if ();
  fdf_event_if ev_if ();

  frame_stream_deframer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_stream  (in_if),
    .event_stream (ev_if),
    .write_en     (write_en),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  always #6 clk = ~clk;

  // stream bytes waiting for the driver, and events the parser still owes us
  logic [7:0]        byte_backlog[$];
  fdf_pkg::result_t  due_events[$];
  int unsigned       bytes_queued = 0;
  int unsigned       mismatches = 0;

  // idling knobs, percent of cycles
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_sender = 1'b0;
  bit          hold_ready = 1'b0;

  // limit registers as the block should hold them
  logic [15:0] lim_ctrl;
  logic [15:0] lim_field;

  // parser state of the prediction
  fdf_pkg::mode_t pmode;
  logic [3:0]     hdr_cnt;
  logic [31:0]    hdr_word;
  logic [31:0]    ctl_len;
  logic [31:0]    ctl_left;
  logic [31:0]    pay_left;

  function automatic int unsigned umin(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // any rejected header word: sticky error mode
  task automatic parser_fault(output fdf_pkg::result_t r);
    pmode = fdf_pkg::MODE_ERROR;
    hdr_cnt = '0;
    r = '0;
    r.event_res = fdf_pkg::EV_ERROR;
  endtask

  // advance the parser by one stream byte; hit tells whether an event results
  task automatic decode_byte(input logic [7:0] b, output bit hit,
                             output fdf_pkg::result_t r);
    logic [32:0] need;
    hit = 1'b1;
    r = '0;
    if (pmode == fdf_pkg::MODE_FIELD_PAY || pmode == fdf_pkg::MODE_FRAME_PAY) begin
      r.event_res = (pmode == fdf_pkg::MODE_FIELD_PAY) ? fdf_pkg::EV_FIELD_BYTE :
                                                         fdf_pkg::EV_FRAME_BYTE;
      r.payload_byte = b;
      pay_left = pay_left - 32'd1;
      r.last_byte = (pay_left == '0);
      if (r.last_byte) begin
        if (pmode == fdf_pkg::MODE_FIELD_PAY && ctl_left != '0)
          pmode = fdf_pkg::MODE_FIELD_HDR;
        else pmode = fdf_pkg::MODE_FRAME_HDR;
      end
    end else if (pmode != fdf_pkg::MODE_CTRL_HDR && pmode != fdf_pkg::MODE_FIELD_HDR &&
                 pmode != fdf_pkg::MODE_FRAME_HDR) begin
      // done or error: every byte is refused
      r.event_res = fdf_pkg::EV_ERROR;
    end else begin
      hdr_word = {hdr_word[23:0], b};
      hdr_cnt = hdr_cnt + 4'd1;
      if (pmode == fdf_pkg::MODE_CTRL_HDR) begin
        if (hdr_cnt == fdf_pkg::HDR_WORD1_END) begin
          if (hdr_word != '0) parser_fault(r);
          else hit = 1'b0;
        end else if (hdr_cnt == fdf_pkg::HDR_WORD2_END) begin
          if (hdr_word > {16'd0, lim_ctrl}) parser_fault(r);
          else begin
            ctl_len = hdr_word;
            hit = 1'b0;
          end
        end else if (hdr_cnt >= fdf_pkg::HDR_WORD3_END) begin
          hdr_cnt = '0;
          if (hdr_word == fdf_pkg::CTRL_ACCEPT || hdr_word == fdf_pkg::CTRL_START ||
              hdr_word == fdf_pkg::CTRL_READY) begin
            // fields follow only when the length leaves room past the type word
            if (ctl_len > fdf_pkg::CTRL_TYPE_BYTES) begin
              pmode = fdf_pkg::MODE_FIELD_HDR;
              ctl_left = ctl_len - fdf_pkg::CTRL_TYPE_BYTES;
            end else begin
              pmode = fdf_pkg::MODE_FRAME_HDR;
            end
            r.event_res = fdf_pkg::EV_CONTROL;
            r.control_kind = hdr_word[2:0];
            r.item_length = ctl_len;
          end else if (hdr_word == fdf_pkg::CTRL_STOP) begin
            pmode = fdf_pkg::MODE_DONE;
            r.event_res = fdf_pkg::EV_STOPPED;
          end else if (hdr_word == fdf_pkg::CTRL_FINISH) begin
            pmode = fdf_pkg::MODE_DONE;
            r.event_res = fdf_pkg::EV_FINISHED;
          end else begin
            parser_fault(r);
          end
        end else begin
          hit = 1'b0;
        end
      end else if (pmode == fdf_pkg::MODE_FIELD_HDR) begin
        if (hdr_cnt == fdf_pkg::HDR_WORD1_END) begin
          if (hdr_word != fdf_pkg::FIELD_CONTENT_TYPE) parser_fault(r);
          else hit = 1'b0;
        end else if (hdr_cnt >= fdf_pkg::HDR_WORD2_END) begin
          hdr_cnt = '0;
          need = {1'b0, hdr_word} + fdf_pkg::FIELD_HDR_BYTES;
          if (hdr_word > {16'd0, lim_field} || {1'b0, ctl_left} < need) begin
            parser_fault(r);
          end else begin
            ctl_left = ctl_left - need[31:0];
            pay_left = hdr_word;
            if (hdr_word != '0) pmode = fdf_pkg::MODE_FIELD_PAY;
            else if (ctl_left != '0) pmode = fdf_pkg::MODE_FIELD_HDR;
            else pmode = fdf_pkg::MODE_FRAME_HDR;
            r.event_res = fdf_pkg::EV_FIELD_HDR;
            r.item_length = hdr_word;
          end
        end else begin
          hit = 1'b0;
        end
      end else begin
        // frame header: a zero length is the escape into a control frame
        if (hdr_cnt >= fdf_pkg::HDR_WORD1_END) begin
          if (hdr_word == '0) begin
            pmode = fdf_pkg::MODE_CTRL_HDR;
            hdr_cnt = fdf_pkg::HDR_WORD1_END;
            hit = 1'b0;
          end else begin
            hdr_cnt = '0;
            pay_left = hdr_word;
            pmode = fdf_pkg::MODE_FRAME_PAY;
            r.event_res = fdf_pkg::EV_FRAME_HDR;
            r.item_length = hdr_word;
          end
        end else begin
          hit = 1'b0;
        end
      end
    end
  endtask

  task automatic flag_mismatch(string what, fdf_pkg::result_t want,
                               fdf_pkg::result_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display({"%t mismatch, %s: want ev=%0d byte=%02h last=%0b kind=%0d len=%0d,",
                " got ev=%0d byte=%02h last=%0b kind=%0d len=%0d"},
               $realtime, what, want.event_res, want.payload_byte, want.last_byte,
               want.control_kind, want.item_length, seen.event_res, seen.payload_byte,
               seen.last_byte, seen.control_kind, seen.item_length);
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: offers the backlog one beat at a time, idling at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= '0;
    end else if (!in_if.valid || in_if.ready) begin
      // current beat (if any) taken this edge, so pick the next one or go idle
      if (byte_backlog.size() != 0 && !hold_sender &&
          $urandom_range(99) >= idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.data_byte <= byte_backlog.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // event sink: stalls at random, or for a long stretch while hold_ready is up
  always @(posedge clk) begin
    if (rst || hold_ready) ev_if.ready <= 1'b0;
    else ev_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // predictor and checker: every accepted byte beat runs through the model,
  // every accepted event beat is matched with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    bit               hit;
    fdf_pkg::result_t pred;
    fdf_pkg::result_t seen;
    fdf_pkg::result_t want;
    if (!rst) begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.data_byte, hit, pred);
        if (hit) due_events.push_back(pred);
      end
      if (ev_if.valid && ev_if.ready) begin
        seen.event_res = fdf_pkg::event_t'(ev_if.event_res);
        seen.payload_byte = ev_if.payload_byte;
        seen.last_byte = ev_if.last_byte;
        seen.control_kind = ev_if.control_kind;
        seen.item_length = ev_if.item_length;
        if (due_events.size() == 0) begin
          flag_mismatch("event with nothing due", '0, seen);
        end else begin
          want = due_events.pop_front();
          if (seen.event_res !== want.event_res ||
              seen.payload_byte !== want.payload_byte ||
              seen.last_byte !== want.last_byte ||
              seen.control_kind !== want.control_kind ||
              seen.item_length !== want.item_length)
            flag_mismatch("wrong event", want, seen);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus building blocks
  // ---------------------------------------------------------------------------
  task automatic put_byte(logic [7:0] b);
    byte_backlog.push_back(b);
    bytes_queued++;
  endtask

  // header words go out big-endian
  task automatic put_word(logic [31:0] w);
    put_byte(w[31:24]);
    put_byte(w[23:16]);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  task automatic put_frame(int unsigned n);
    put_word(n);
    repeat (n) put_byte(8'($urandom));
  endtask

  // well-formed control frame under the current limits; fields must add up
  // exactly to the control length, so lengths are drawn from what is left
  task automatic put_control(logic [31:0] kind, int unsigned nfields);
    int unsigned budget;
    int unsigned total;
    int unsigned flen;
    int unsigned cap;
    int unsigned lens[$];
    budget = (lim_ctrl > 16'd4) ? lim_ctrl - 4 : 0;
    total = 0;
    while (lens.size() < nfields && budget >= 8) begin
      cap = ($urandom_range(29) == 0) ? 300 : 12;
      flen = $urandom_range(0, umin(umin(lim_field, budget - 8), cap));
      lens.push_back(flen);
      budget -= 8 + flen;
      total += 8 + flen;
    end
    put_word('0);
    // no fields: a short control, length 4 or below
    put_word(lens.size() == 0 ? $urandom_range(0, umin(4, lim_ctrl)) : 4 + total);
    put_word(kind);
    foreach (lens[i]) begin
      put_word(fdf_pkg::FIELD_CONTENT_TYPE);
      put_word(lens[i]);
      repeat (lens[i]) put_byte(8'($urandom));
    end
  endtask

  task automatic put_random_unit();
    int unsigned pick;
    logic [31:0] kind;
    pick = $urandom_range(99);
    if (pick < 60) put_frame($urandom_range(1, 16));
    else if (pick < 64) put_frame($urandom_range(17, 80));
    else if (pick < 65) put_frame($urandom_range(256, 300));
    else begin
      case ($urandom_range(2))
        0: kind = fdf_pkg::CTRL_ACCEPT;
        1: kind = fdf_pkg::CTRL_START;
        default: kind = fdf_pkg::CTRL_READY;
      endcase
      put_control(kind, $urandom_range(0, 3));
    end
  endtask

  task automatic fill_random(int unsigned n);
    int unsigned goal;
    goal = bytes_queued + n;
    while (bytes_queued < goal) put_random_unit();
  endtask

  // the one way out of normal parsing: stop, finish or a rejected header word,
  // then junk that must all come back as errors
  task automatic put_broken_end();
    logic [31:0] w;
    case ($urandom_range(5))
      0: begin
        put_word('0);
        put_word($urandom_range(0, lim_ctrl));
        put_word(fdf_pkg::CTRL_STOP);
      end
      1: begin
        put_word('0);
        put_word($urandom_range(0, lim_ctrl));
        put_word(fdf_pkg::CTRL_FINISH);
      end
      2: begin
        // control length over the limit
        put_word('0);
        put_word($urandom_range(0, 1) ? 32'hFFFF_FFFF :
                 lim_ctrl + 1 + $urandom_range(0, 999));
      end
      3: begin
        // unknown control type
        put_word('0);
        put_word($urandom_range(0, umin(4, lim_ctrl)));
        put_word($urandom_range(0, 1) ? 32'd0 : $urandom_range(6, 32'hFFFF_FFFF));
      end
      4: begin
        // field that is not content type
        w = $urandom_range(0, 1) ? 32'd0 : $urandom_range(2, 32'hFFFF_FFFF);
        put_word('0);
        put_word(32'd20);
        put_word(fdf_pkg::CTRL_ACCEPT);
        put_word(w);
      end
      default: begin
        // field over its limit, or one that overruns the control length
        put_word('0);
        put_word(32'd14);
        put_word(fdf_pkg::CTRL_START);
        put_word(fdf_pkg::FIELD_CONTENT_TYPE);
        if ($urandom_range(0, 1)) put_word(lim_field + 1 + $urandom_range(0, 99));
        else put_word($urandom_range(3, lim_field));
      end
    endcase
    repeat (40) put_byte(8'($urandom));
  endtask

  task automatic set_limit(fdf_pkg::reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    write_en <= 1'b1;
    reg_index <= idx;
    write_data <= val;
    if (idx == fdf_pkg::REG_CONTROL_LEN_LIMIT) lim_ctrl = val;
    else lim_field = val;
  endtask

  task automatic set_limits(logic [15:0] ctrl_val, logic [15:0] field_val);
    set_limit(fdf_pkg::REG_CONTROL_LEN_LIMIT, ctrl_val);
    set_limit(fdf_pkg::REG_FIELD_LEN_LIMIT, field_val);
    @(posedge clk);
    write_en <= 1'b0;
    @(negedge clk);
  endtask

  // idle point: backlog sent, nothing due, then room for bytes that make no
  // event but may still sit in the intake queue or the parser
  task automatic wait_drained();
    while (byte_backlog.size() != 0 || in_if.valid || due_events.size() != 0)
      @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    ev_if.ready = 1'b0;
    write_en = 1'b0;
    reg_index = fdf_pkg::REG_CONTROL_LEN_LIMIT;
    write_data = '0;
    lim_ctrl = fdf_pkg::CONTROL_LEN_LIMIT_RESET;
    lim_field = fdf_pkg::FIELD_LEN_LIMIT_RESET;
    pmode = fdf_pkg::MODE_CTRL_HDR;
    hdr_cnt = '0;
    hdr_word = '0;
    ctl_len = '0;
    ctl_left = '0;
    pay_left = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limits, no idling; directed opening first
    // short control of length zero, one-byte frame of all ones
    put_word('0);
    put_word('0);
    put_word(fdf_pkg::CTRL_ACCEPT);
    put_word(32'd1);
    put_byte(8'hFF);
    // ready control carrying one zero-length field
    put_word('0);
    put_word(32'd12);
    put_word(fdf_pkg::CTRL_READY);
    put_word(fdf_pkg::FIELD_CONTENT_TYPE);
    put_word('0);
    // two-byte frame with both byte extremes
    put_word(32'd2);
    put_byte(8'h00);
    put_byte(8'hFF);
    fill_random(200);
    wait_drained();

    // widest limits, sender mostly idle
    set_limits(16'hFFFF, 16'hFFFF);
    idle_pct = 77;
    fill_random(220);
    wait_drained();

    // zero limits: only zero-length controls pass; receiver mostly stalled
    set_limits(16'h0000, 16'h0000);
    idle_pct = 0;
    stall_pct = 77;
    fill_random(220);
    wait_drained();

    // tight limits, both sides idling now and then
    set_limits(16'd40, 16'd5);
    idle_pct = 23;
    stall_pct = 23;
    fill_random(220);
    wait_drained();

    // back pressure: receiver holds off long enough for the intake queue to
    // fill and drop ready, while the sender keeps offering beats
    set_limits(16'($urandom_range(12, 2000)), 16'($urandom_range(0, 400)));
    idle_pct = 0;
    stall_pct = 0;
    fill_random(100);
    fork
      begin
        @(posedge clk);
        hold_ready <= 1'b1;
        repeat (80) @(posedge clk);
        hold_ready <= 1'b0;
      end
    join_none
    while (byte_backlog.size() != 0) @(negedge clk);
    // sender pauses until the parser has caught up completely
    hold_sender = 1'b1;
    while (due_events.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    hold_sender = 1'b0;
    fill_random(100);
    wait_drained();

    // closing: a few good units, then stop, finish or a bad header word
    set_limits(16'd100, 16'd50);
    idle_pct = $urandom_range(0, 1) ? 23 : 77;
    stall_pct = $urandom_range(0, 1) ? 0 : 23;
    fill_random(30);
    put_broken_end();
    wait_drained();

    if (mismatches == 0 && due_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
